[src/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define FTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define FTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ftc_pkg.sv]
// Shared types, constants and the byte-wide CRC-32 update for the tag checker.
// No dependencies.
package ftc_pkg;

   localparam logic [7:0]  TAG_RESET     = 8'h33;
   localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
   localparam int          TRAILER_BYTES = 4;
   localparam logic [2:0]  FULL_POS      = 3'(TRAILER_BYTES + 1);

   typedef enum logic [1:0] {
      VERDICT_CLAIMED   = 2'd0,
      VERDICT_BROKEN    = 2'd1,
      VERDICT_UNCLAIMED = 2'd2
   } verdict_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        verdict_valid;
      verdict_type verdict;
   } result_type;

   // Reflected CRC-32 over one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

[src/ftc_if.sv]
// Valid/ready channel interfaces for the tag checker: request, response, CSR write.
// No dependencies.
interface ftc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;
   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface ftc_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       verdict_valid;
   logic [1:0] verdict;
   modport source (output valid, output payload_valid, output payload_byte,
                   output verdict_valid, output verdict, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input verdict_valid, input verdict, output ready);
endinterface

interface ftc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[src/ftc_csr.sv]
// Tag register behind the CSR write channel.
// Depends on ftc_pkg.
module ftc_csr
   import ftc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_valid,
   output logic       wr_ready,
   input  logic [7:0] wr_data,
   output logic [7:0] magic
);

   logic [7:0] magic_ff;
   logic [7:0] magic_in;

   assign wr_ready = 1'b1;
   assign magic_in = (wr_valid && wr_ready) ? wr_data : magic_ff;
   assign magic    = magic_ff;

   always_ff @(posedge clock) begin
      if (reset) magic_ff <= TAG_RESET;
      else       magic_ff <= magic_in;
   end

endmodule

[src/ftc_core.sv]
// Frame state, delay line, CRC accumulation and verdict for one byte per transfer.
// Depends on ftc_pkg.
module ftc_core
   import ftc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       last_byte,
   input  logic [7:0] magic,
   output result_type result
);

   logic [31:0] crc_ff,  crc_in,  crc_next;
   logic [31:0] tail_ff, tail_in, tail_next;
   logic [2:0]  pos_ff,  pos_in,  pos_next;
   logic        tag_ff,  tag_in,  tag_next;

   always_comb begin
      result    = '{payload_valid: 1'b0, payload_byte: 8'h00,
                    verdict_valid: 1'b0, verdict: VERDICT_CLAIMED};
      crc_next  = crc_ff;
      tail_next = tail_ff;
      tag_next  = tag_ff;
      if (pos_ff == 3'd0) begin
         crc_next  = '0;
         tail_next = '0;
         tag_next  = (rx_byte == magic);
      end else begin
         if (pos_ff >= FULL_POS && tag_ff) begin
            result.payload_valid = 1'b1;
            result.payload_byte  = tail_ff[7:0];
            crc_next             = crc_byte(crc_ff, tail_ff[7:0]);
         end
         tail_next = {rx_byte, tail_ff[31:8]};
      end
      pos_next = (pos_ff >= FULL_POS) ? FULL_POS : pos_ff + 3'd1;

      crc_in  = crc_next;
      tail_in = tail_next;
      tag_in  = tag_next;
      pos_in  = pos_next;
      if (last_byte) begin
         result.verdict_valid = 1'b1;
         if (pos_ff == 3'd0 || !tag_next)  result.verdict = VERDICT_UNCLAIMED;
         else if (pos_next < FULL_POS)     result.verdict = VERDICT_BROKEN;
         else if (crc_next == tail_next)   result.verdict = VERDICT_CLAIMED;
         else                              result.verdict = VERDICT_BROKEN;
         // drop frame state so the next transfer opens a new frame
         crc_in  = '0;
         tail_in = '0;
         tag_in  = 1'b0;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= '0;
         tail_ff <= '0;
         pos_ff  <= '0;
         tag_ff  <= 1'b0;
      end else if (accept) begin
         crc_ff  <= crc_in;
         tail_ff <= tail_in;
         pos_ff  <= pos_in;
         tag_ff  <= tag_in;
      end
   end

endmodule

[src/ftc_out_reg.sv]
// Response register: holds one result until the sink takes it.
// Depends on ftc_pkg.
module ftc_out_reg
   import ftc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       take,
   output logic       full,
   output result_type data
);

   logic       valid_ff, valid_in;
   result_type data_ff,  data_in;

   assign valid_in = load | (valid_ff & ~take);
   assign data_in  = load ? load_data : data_ff;
   assign full     = valid_ff;
   assign data     = data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= data_in;
   end

endmodule

[src/frame_tag_crc32_checker.sv]
// Latency: a result appears on rsp_bus the cycle after its byte's req_bus transfer.
// Throughput: one byte per cycle unless the sink stalls; the response register
// frees as it is taken, so only the CRC byte update and the trailer compare set
// the cycle time. Reset (synchronous, active high) clears frame state, empties the
// response register and returns the tag register to 0x33.
// Depends on ftc_pkg, ftc_if, ftc_csr, ftc_core, ftc_out_reg.
module frame_tag_crc32_checker
   import ftc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   ftc_req_if.sink   req_bus,
   ftc_rsp_if.source rsp_bus,
   ftc_csr_if.sink   csr_bus
);

   logic       req_transfer;
   logic       rsp_full;
   logic [7:0] magic;
   result_type core_result;
   result_type rsp_data;

   // Tag register; to be written only between frames, which the block does not enforce
   ftc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_data  (csr_bus.data),
      .magic    (magic)
   );

   // Accept whenever the response register is empty or being drained this cycle
   assign req_bus.ready = ~rsp_full | rsp_bus.ready;
   assign req_transfer  = req_bus.valid & req_bus.ready;

   // Advance frame state and build the result in the same pass
   ftc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_transfer),
      .rx_byte   (req_bus.rx_byte),
      .last_byte (req_bus.last_byte),
      .magic     (magic),
      .result    (core_result)
   );

   // Hold the result until the sink takes it
   ftc_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_transfer),
      .load_data (core_result),
      .take      (rsp_bus.ready),
      .full      (rsp_full),
      .data      (rsp_data)
   );

   assign rsp_bus.valid         = rsp_full;
   assign rsp_bus.payload_valid = rsp_data.payload_valid;
   assign rsp_bus.payload_byte  = rsp_data.payload_byte;
   assign rsp_bus.verdict_valid = rsp_data.verdict_valid;
   assign rsp_bus.verdict       = rsp_data.verdict;

endmodule

[src/ftc_checker.sv]
// Port-level checks for the tag checker, bound to its top level.
// Depends on ftc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ftc_checker
   import ftc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       payload_valid,
   input logic [7:0] payload_byte,
   input logic       verdict_valid,
   input logic [1:0] verdict
);

   logic rsp_stalled;
   logic req_transfer;
   logic payload_clean;
   logic verdict_ok;

   assign rsp_stalled   = rsp_valid && !rsp_ready;
   assign req_transfer  = req_valid && req_ready;
   assign payload_clean = payload_valid || (payload_byte == 8'h00);
   assign verdict_ok    = verdict_valid ? (verdict == VERDICT_CLAIMED ||
                                           verdict == VERDICT_BROKEN ||
                                           verdict == VERDICT_UNCLAIMED)
                                        : (verdict == VERDICT_CLAIMED);

   `FTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid, "response dropped")
   `FTC_ASSERT_NOW(a_ready_empty, clock, reset, !rsp_valid, req_ready, "stall while empty")
   `FTC_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_transfer, rsp_valid, "no response")
   `FTC_ASSERT_NOW(a_payload_zero, clock, reset, rsp_valid, payload_clean, "stray payload byte")
   `FTC_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid, verdict_ok, "bad verdict field")

endmodule

bind frame_tag_crc32_checker ftc_checker u_ftc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .payload_valid (rsp_bus.payload_valid),
   .payload_byte  (rsp_bus.payload_byte),
   .verdict_valid (rsp_bus.verdict_valid),
   .verdict       (rsp_bus.verdict)
);

[bench/tb_frame_tag_crc32_checker.sv]
// Self-checking bench for the tagged-frame CRC-32 checker and deframer.
// Depends on ftc_pkg, the ftc_if channel interfaces and frame_tag_crc32_checker.
`timescale 1ns / 1ps

module tb_frame_tag_crc32_checker
   import ftc_pkg::*;
();

   typedef logic [7:0] octet_q_type[$];

   // Generous bound for about 1.5k bytes under the heaviest idling
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 50;

   logic clock;
   logic reset;

   ftc_req_if req_bus ();
   ftc_rsp_if rsp_bus ();
   ftc_csr_if csr_bus ();

   frame_tag_crc32_checker dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Bench copy of the deframer state and the tag register
   logic [7:0]  tag_q;
   logic [31:0] crc_q;
   logic [31:0] tail_q;
   logic [2:0]  pos_q;
   logic        tagged_q;

   // Deframer outputs owed by the DUT, oldest first
   result_type  frame_out_q[$];

   int n_sent;
   int n_checked;
   int n_errors;
   int cycle_count;
   int send_gap;     // percent of cycles the byte source holds off
   int rsp_stall;    // percent of cycles the result sink stalls

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reflected CRC-32 fold of one byte, one data bit at a time
   function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c  = {1'b0, c[31:1]};
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic void clear_frame_state();
      crc_q    = '0;
      tail_q   = '0;
      pos_q    = '0;
      tagged_q = 1'b0;
   endfunction

   // Advance the bench deframer by one byte and return what the DUT must emit
   function automatic result_type deframe_octet(input logic [7:0] data, input logic eof);
      result_type r;
      logic [2:0] p;
      r = '0;
      p = pos_q;
      if (p == 3'd0) begin
         // first byte of a frame: judge the tag, never emit it
         crc_q    = '0;
         tail_q   = '0;
         tagged_q = (data == tag_q);
      end else begin
         // the byte leaving the delay line is payload once the line is full
         if (p >= FULL_POS && tagged_q) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = tail_q[7:0];
            crc_q           = crc_fold(crc_q, tail_q[7:0]);
         end
         tail_q = {data, tail_q[31:8]};
      end
      pos_q = (p >= FULL_POS) ? FULL_POS : p + 3'd1;
      if (eof) begin
         r.verdict_valid = 1'b1;
         if (p == 3'd0 || !tagged_q)
            r.verdict = VERDICT_UNCLAIMED;
         else if (pos_q < FULL_POS)
            r.verdict = VERDICT_BROKEN;     // tagged but too short for a trailer
         else
            r.verdict = (crc_q == tail_q) ? VERDICT_CLAIMED : VERDICT_BROKEN;
         clear_frame_state();
      end
      return r;
   endfunction

   // Tag, random payload, little-endian CRC trailer; optionally flip one bit after the tag
   function automatic octet_q_type tagged_frame(input logic [7:0] tag, input int n_payload,
                                                input bit corrupt);
      octet_q_type f;
      logic [31:0] c;
      logic [7:0]  d;
      int          k;
      c = '0;
      f.push_back(tag);
      for (int i = 0; i < n_payload; i++) begin
         d = 8'($urandom);
         f.push_back(d);
         c = crc_fold(c, d);
      end
      for (int i = 0; i < 4; i++) f.push_back(c[8*i +: 8]);
      if (corrupt) begin
         k    = $urandom_range(f.size() - 1, 1);
         f[k] = f[k] ^ (8'h01 << $urandom_range(7, 0));
      end
      return f;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (n_errors < MAX_REPORTS)
         $display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, got, want);
      n_errors++;
   endtask

   // Hold valid low for the random gap, then offer one byte until it transfers
   task automatic send_octet(input logic [7:0] data, input logic eof);
      while ($urandom_range(99) < send_gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.rx_byte   <= data;
      req_bus.last_byte <= eof;
      do @(posedge clock); while (!req_bus.ready);
      frame_out_q.push_back(deframe_octet(data, eof));
      n_sent++;
   endtask

   task automatic send_frame(input octet_q_type f);
      foreach (f[i]) send_octet(f[i], i == f.size() - 1);
   endtask

   // Drop valid and hold off until every owed result has been taken
   task automatic wait_results_done();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (n_checked < n_sent) @(posedge clock);
   endtask

   // Write the tag register with the block drained; the bench copy follows the transfer
   task automatic write_tag(input logic [7:0] v);
      wait_results_done();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      tag_q = v;
      csr_bus.valid <= 1'b0;
   endtask

   // Result sink: stall at the rate of the current phase
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall);
   end

   // Compare every result transfer with the oldest owed output, field by field
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_out_q.size() == 0) begin
            report_mismatch("result with nothing owed", 32'(rsp_bus.payload_byte), 0);
         end else begin
            want = frame_out_q.pop_front();
            if (rsp_bus.payload_valid !== want.payload_valid)
               report_mismatch("payload_valid", 32'(rsp_bus.payload_valid),
                               32'(want.payload_valid));
            if (rsp_bus.payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", 32'(rsp_bus.payload_byte),
                               32'(want.payload_byte));
            if (rsp_bus.verdict_valid !== want.verdict_valid)
               report_mismatch("verdict_valid", 32'(rsp_bus.verdict_valid),
                               32'(want.verdict_valid));
            if (rsp_bus.verdict !== want.verdict)
               report_mismatch("verdict", 32'(rsp_bus.verdict), 32'(want.verdict));
         end
         n_checked++;
      end
   end

   // Watchdog: end the run if the traffic stalls for good
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Corner frames at the reset tag: every verdict and every short length
   task automatic test_directed_frames();
      send_frame('{TAG_RESET});                              // one byte, tag matches
      send_frame('{8'h00});                                  // one byte, no tag
      send_frame('{8'hFF, TAG_RESET, 8'h00});                // wrong tag
      send_frame('{TAG_RESET, 8'hFF});                       // tagged, two bytes
      send_frame('{TAG_RESET, 8'h00, 8'hFF, 8'h80});         // tagged, four bytes
      send_frame('{TAG_RESET, 8'h00, 8'h00, 8'h00, 8'h00});  // empty payload, zero trailer
      send_frame('{TAG_RESET, 8'h00, 8'h00, 8'h00, 8'h01});  // empty payload, bad trailer
      send_frame(tagged_frame(TAG_RESET, 1, 1'b0));          // one payload byte, good CRC
   endtask

   // Change the tag mid-frame: the frame in flight keeps the tag it was judged with
   task automatic test_tag_change_midframe();
      octet_q_type f;
      f = tagged_frame(TAG_RESET, 2, 1'b0);
      send_octet(f[0], 1'b0);
      send_octet(f[1], 1'b0);
      write_tag(8'h5A);
      for (int i = 2; i < f.size(); i++) send_octet(f[i], i == f.size() - 1);
      send_frame(tagged_frame(8'h5A, 3, 1'b0));
      send_frame(tagged_frame(TAG_RESET, 3, 1'b0));          // old tag is now foreign
   endtask

   // Mostly well-formed frames with random content, the rest corrupt, foreign, short or noise
   task automatic test_random_frames(input int n_items);
      octet_q_type f;
      int          start;
      int          kind;
      int          len;
      start = n_sent;
      while (n_sent - start < n_items) begin
         kind = $urandom_range(99);
         len  = ($urandom_range(99) < 85) ? $urandom_range(8, 0) : $urandom_range(40, 9);
         f.delete();
         if (kind < 60) begin
            f = tagged_frame(tag_q, len, 1'b0);
         end else if (kind < 75) begin
            f = tagged_frame(tag_q, len, 1'b1);
         end else if (kind < 85) begin
            f = tagged_frame(tag_q ^ 8'($urandom_range(255, 1)), len, 1'b0);
         end else if (kind < 95) begin
            // tagged but cut short of a full trailer
            f.push_back(tag_q);
            repeat ($urandom_range(3, 0)) f.push_back(8'($urandom));
         end else begin
            // noise: random bytes, sometimes led by the tag
            repeat ($urandom_range(10, 1)) f.push_back(8'($urandom));
            if ($urandom_range(1)) f[0] = tag_q;
         end
         send_frame(f);
         // now and then pause the source until the block has caught up
         if ($urandom_range(29) == 0) wait_results_done();
      end
   endtask

   // Tag register at both ends of its range
   task automatic test_tag_extremes();
      write_tag(8'h00);
      test_random_frames(100);
      write_tag(8'hFF);
      test_random_frames(100);
   endtask

   // Long random traffic under one idle pattern with a fresh random tag
   task automatic test_random_traffic(input int gap, input int stall);
      write_tag(8'($urandom));
      send_gap  = gap;
      rsp_stall = stall;
      test_random_frames(400);
   endtask

   initial begin
      n_sent    = 0;
      n_checked = 0;
      n_errors  = 0;
      send_gap  = 8;
      rsp_stall = 64;
      tag_q     = TAG_RESET;
      clear_frame_state();

      // drive every input to a known value before the first edge
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.rx_byte   <= '0;
      req_bus.last_byte <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_tag_change_midframe();
      test_tag_extremes();
      test_random_traffic(8, 64);
      test_random_traffic(64, 8);
      test_random_traffic(0, 0);

      // drain, then give any stray result time to show up
      wait_results_done();
      repeat (4) @(posedge clock);
      if (n_errors == 0 && frame_out_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
